@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");
// next-cycle implication
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ src/hsoc_pkg.sv @@
// ----------------------------------------------------------------------------
// Heap sorter package
// Sizes, tally control struct and shared constants.
// ----------------------------------------------------------------------------
package hsoc_pkg;

	localparam int MAX_ITEMS = 64;
	localparam int ADDR_W    = $clog2(MAX_ITEMS);
	localparam int CNT_W     = ADDR_W + 1;
	localparam int DATA_W    = 32;
	localparam int TALLY_W   = 16;

	// tally commands from the sequencer
	typedef struct packed {
		logic clr;
		logic add_cmp;
		logic add_asg;
	} tally_op_t;

endpackage

@@ src/heap_sorter_with_op_counts.sv @@
// ----------------------------------------------------------------------------
// Heap sorter with operation counts
// Loads a set of signed words, heap-sorts them in place in a local memory
// with one shared comparator, then streams them out in ascending order.
// ----------------------------------------------------------------------------
//  Channel   | Dir | Handshake          | Contents
//  s_axis    | in  | s_tvalid/s_tready  | tdata: value[31:0]; tlast: last_item
//  m_axis    | out | m_tvalid/m_tready  | tdata: sorted_value[31:0],
//            |     |                    |   comparison_count[47:32],
//            |     |                    |   assignment_count[63:48];
//            |     |                    | tlast: last_out
//
// Loading takes one value per cycle. The set closes on tlast or on the
// 64th value. Sorting runs on the shared comparator and the two-read memory:
// each sift fetches its root, each visit reads both children and compares
// them in turn, a larger child is swapped in, and each extraction swaps the
// root with the last leaf; each result is held until m_tready takes it.
// s_tready is low from set close until the last result is taken. Reset
// clears control only; the memory has no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module heap_sorter_with_op_counts
	import hsoc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // value[31:0]
	input  logic        s_tlast,   // last_item
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // sorted_value[31:0], comparison_count[47:32],
	                               // assignment_count[63:48]
	output logic        m_tlast    // last_out
);

	localparam logic [3:0] ST_LOAD     = 4'd0;
	localparam logic [3:0] ST_BUILD    = 4'd1;
	localparam logic [3:0] ST_XTRACT   = 4'd2;
	localparam logic [3:0] ST_XSWAP_W0 = 4'd3;
	localparam logic [3:0] ST_XSWAP_W1 = 4'd4;
	localparam logic [3:0] ST_SIFT_RD  = 4'd5;
	localparam logic [3:0] ST_SIFT_CUR = 4'd6;
	localparam logic [3:0] ST_VISIT_RD = 4'd7;
	localparam logic [3:0] ST_CMP_L    = 4'd8;
	localparam logic [3:0] ST_CMP_R    = 4'd9;
	localparam logic [3:0] ST_SWAP_W0  = 4'd10;
	localparam logic [3:0] ST_SWAP_W1  = 4'd11;
	localparam logic [3:0] ST_EMIT_RD  = 4'd12;
	localparam logic [3:0] ST_EMIT_LD  = 4'd13;
	localparam logic [3:0] ST_EMIT_WT  = 4'd14;

	logic [3:0]        state_q, state_d;
	logic [CNT_W-1:0]  cnt_q, n_q, outer_q, len_q;
	logic [ADDR_W-1:0] node_q, top_q, k_q;
	logic              build_q;
	logic [DATA_W-1:0] cur_val_q, top_val_q;
	logic [DATA_W-1:0] mem [MAX_ITEMS];
	logic [DATA_W-1:0] rd_a_q, rd_b_q;
	logic [63:0]       m_tdata_q;
	logic              m_tvalid_q, m_tlast_q;

	logic              s_acc, m_acc, set_close;
	logic [CNT_W-1:0]  outer_m1;
	logic [CNT_W:0]    left_idx, right_idx;
	logic              left_ok, right_ok;
	logic              re;
	logic [ADDR_W-1:0] ra, rb;
	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [DATA_W-1:0] wdata;
	logic [DATA_W-1:0] cmp_a, cmp_b;
	logic              cmp_gt;
	logic [ADDR_W-1:0] new_top;
	tally_op_t         tally_op;
	logic [TALLY_W-1:0] cmp_count, asg_count;

	assign s_tready  = (state_q == ST_LOAD);
	assign s_acc     = s_tvalid & s_tready;
	assign m_acc     = m_tvalid_q & m_tready;
	assign set_close = s_acc & (s_tlast | (cnt_q == CNT_W'(MAX_ITEMS - 1)));
	assign outer_m1  = outer_q - CNT_W'(1);

	// child indices of the sift node, compared against the heap length
	assign left_idx  = {1'b0, node_q, 1'b1};
	assign right_idx = left_idx + (CNT_W+1)'(1);
	assign left_ok   = left_idx < {1'b0, len_q};
	assign right_ok  = right_idx < {1'b0, len_q};

	// shared signed comparator
	assign cmp_a  = (state_q == ST_CMP_R) ? rd_b_q : rd_a_q;
	assign cmp_b  = (state_q == ST_CMP_R) ? top_val_q : cur_val_q;
	assign cmp_gt = $signed(cmp_a) > $signed(cmp_b);

	assign new_top = (right_ok & cmp_gt) ? right_idx[ADDR_W-1:0] : top_q;

	// memory port selection
	always_comb begin
		re    = 1'b0;
		ra    = node_q;
		rb    = node_q;
		we    = 1'b0;
		waddr = node_q;
		wdata = top_val_q;
		case (state_q)
			ST_LOAD: begin
				we    = s_acc;
				waddr = cnt_q[ADDR_W-1:0];
				wdata = s_tdata;
			end
			ST_XTRACT: begin
				re = 1'b1;
				ra = '0;
				rb = outer_m1[ADDR_W-1:0];
			end
			ST_XSWAP_W0: begin
				we    = 1'b1;
				waddr = '0;
				wdata = rd_b_q;
			end
			ST_XSWAP_W1: begin
				we    = 1'b1;
				waddr = outer_m1[ADDR_W-1:0];
				wdata = rd_a_q;
			end
			ST_SIFT_RD: begin
				re = 1'b1;
				ra = node_q;
			end
			ST_VISIT_RD: begin
				re = 1'b1;
				ra = left_idx[ADDR_W-1:0];
				rb = right_idx[ADDR_W-1:0];
			end
			ST_SWAP_W0: begin
				we    = 1'b1;
				waddr = node_q;
				wdata = top_val_q;
			end
			ST_SWAP_W1: begin
				we    = 1'b1;
				waddr = top_q;
				wdata = cur_val_q;
			end
			ST_EMIT_RD: begin
				re = 1'b1;
				ra = k_q;
			end
			default: begin
				re = 1'b0;
			end
		endcase
	end

	// element store: one write, two registered reads
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_a_q <= mem[ra];
			rd_b_q <= mem[rb];
		end
	end

	// tally commands
	always_comb begin
		tally_op.clr     = set_close | (state_q == ST_EMIT_WT && m_acc && m_tlast_q);
		tally_op.add_cmp = (state_q == ST_VISIT_RD);
		tally_op.add_asg = (state_q == ST_XSWAP_W1) | (state_q == ST_SWAP_W1);
	end

	hsoc_tally u_tally (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (tally_op),
		.cmp_count (cmp_count),
		.asg_count (asg_count)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD:     if (set_close) state_d = ST_BUILD;
			ST_BUILD:    state_d = (outer_q == '0) ? ST_XTRACT : ST_SIFT_RD;
			ST_XTRACT:   state_d = (outer_q == '0) ? ST_EMIT_RD : ST_XSWAP_W0;
			ST_XSWAP_W0: state_d = ST_XSWAP_W1;
			ST_XSWAP_W1: state_d = ST_SIFT_RD;
			ST_SIFT_RD:  state_d = ST_SIFT_CUR;
			ST_SIFT_CUR: state_d = ST_VISIT_RD;
			ST_VISIT_RD: state_d = ST_CMP_L;
			ST_CMP_L:    state_d = ST_CMP_R;
			ST_CMP_R: begin
				if (new_top == node_q) begin
					state_d = build_q ? ST_BUILD : ST_XTRACT;
				end else begin
					state_d = ST_SWAP_W0;
				end
			end
			ST_SWAP_W0:  state_d = ST_SWAP_W1;
			ST_SWAP_W1:  state_d = ST_VISIT_RD;
			ST_EMIT_RD:  state_d = ST_EMIT_LD;
			ST_EMIT_LD:  state_d = ST_EMIT_WT;
			ST_EMIT_WT: begin
				if (m_acc) state_d = m_tlast_q ? ST_LOAD : ST_EMIT_RD;
			end
			default:     state_d = ST_LOAD;
		endcase
	end

	// sequencer control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			cnt_q      <= '0;
			n_q        <= '0;
			outer_q    <= '0;
			len_q      <= '0;
			node_q     <= '0;
			top_q      <= '0;
			k_q        <= '0;
			build_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_LOAD: begin
					if (s_acc) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					if (set_close) begin
						n_q     <= cnt_q + CNT_W'(1);
						outer_q <= cnt_q + CNT_W'(1);
						build_q <= 1'b1;
					end
				end
				ST_BUILD: begin
					if (outer_q == '0) begin
						outer_q <= n_q;
						build_q <= 1'b0;
					end else begin
						node_q  <= outer_m1[ADDR_W-1:0];
						len_q   <= n_q;
						outer_q <= outer_m1;
					end
				end
				ST_XTRACT: begin
					k_q <= '0;
				end
				ST_XSWAP_W1: begin
					node_q  <= '0;
					len_q   <= outer_m1;
					outer_q <= outer_m1;
				end
				ST_CMP_L: begin
					top_q <= (left_ok & cmp_gt) ? left_idx[ADDR_W-1:0] : node_q;
				end
				ST_CMP_R: begin
					top_q <= new_top;
				end
				ST_SWAP_W1: begin
					node_q <= top_q;
				end
				ST_EMIT_LD: begin
					m_tvalid_q <= 1'b1;
				end
				ST_EMIT_WT: begin
					if (m_acc) begin
						m_tvalid_q <= 1'b0;
						k_q        <= k_q + ADDR_W'(1);
						if (m_tlast_q) begin
							cnt_q <= '0;
						end
					end
				end
				default: begin
					build_q <= build_q;
				end
			endcase
		end
	end

	// sift values and output payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_SIFT_CUR: cur_val_q <= rd_a_q;
			ST_CMP_L:    top_val_q <= (left_ok & cmp_gt) ? rd_a_q : cur_val_q;
			ST_CMP_R: begin
				if (right_ok & cmp_gt) begin
					top_val_q <= rd_b_q;
				end
			end
			ST_EMIT_LD: begin
				m_tdata_q <= {asg_count, cmp_count, rd_a_q};
				m_tlast_q <= ({1'b0, k_q} + CNT_W'(1)) == n_q;
			end
			default: begin
				cur_val_q <= cur_val_q;
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	// input and output sides never open together
	`ASSERT_IMP(a_no_overlap, clk, arst_n, s_tready, !m_tvalid)
	// a full store closes the set
	`ASSERT_NXT(a_full_close, clk, arst_n, s_acc && (cnt_q == CNT_W'(MAX_ITEMS - 1)), !s_tready)
	// the final result reopens loading
	`ASSERT_NXT(a_reopen, clk, arst_n, m_acc && m_tlast, s_tready)
	// emission index stays inside the set
	`ASSERT_IMP(a_emit_range, clk, arst_n, state_q == ST_EMIT_LD, {1'b0, k_q} < n_q)

endmodule

@@ src/hsoc_tally.sv @@
// ----------------------------------------------------------------------------
// Heap sorter operation tallies
// Saturating comparison (+2 per sift visit) and assignment (+3 per swap)
// counters.
// ----------------------------------------------------------------------------
module hsoc_tally
	import hsoc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  tally_op_t          op,
	output logic [TALLY_W-1:0] cmp_count,
	output logic [TALLY_W-1:0] asg_count
);

	localparam logic [TALLY_W:0] TallyMax = {1'b0, {TALLY_W{1'b1}}};

	logic [TALLY_W-1:0] cmp_q, asg_q;
	logic [TALLY_W:0]   cmp_sum, asg_sum;

	// add with headroom, then clamp
	assign cmp_sum = {1'b0, cmp_q} + (TALLY_W+1)'(2);
	assign asg_sum = {1'b0, asg_q} + (TALLY_W+1)'(3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_q <= '0;
			asg_q <= '0;
		end else if (op.clr) begin
			cmp_q <= '0;
			asg_q <= '0;
		end else begin
			if (op.add_cmp) begin
				cmp_q <= (cmp_sum > TallyMax) ? TallyMax[TALLY_W-1:0] : cmp_sum[TALLY_W-1:0];
			end
			if (op.add_asg) begin
				asg_q <= (asg_sum > TallyMax) ? TallyMax[TALLY_W-1:0] : asg_sum[TALLY_W-1:0];
			end
		end
	end

	assign cmp_count = cmp_q;
	assign asg_count = asg_q;

endmodule
